// ===== src/radix40_key_unpack_core_macros.svh =====
// ============================================================================
// radix40_key_unpack_core_macros
// assertion macros shared by the key unpack rtl, clocked on i_clk and
// disabled while i_rst_n is low
// ============================================================================
`ifndef RADIX40_KEY_UNPACK_CORE_MACROS_SVH
`define RADIX40_KEY_UNPACK_CORE_MACROS_SVH

// plain invariant, checked on every edge out of reset
`define R40KU_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// same-cycle implication
`define R40KU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define R40KU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/r40ku_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// r40ku_pkg
// types, reciprocal constants and the symbol alphabet of the key unpacker
// ============================================================================
package r40ku_pkg;

    localparam int unsigned C_LEN_W = 7;

    // digit positions per word, the top quotient follows them
    localparam logic [2:0] C_HEAD_DIGITS = 3'd3;
    localparam logic [2:0] C_REST_DIGITS = 3'd5;

    // largest legal symbol code
    localparam logic [16:0] C_TOP_MAX = 17'd39;

    // ceil(2^s / 5^k): w / 40^k = (w >> 3k) / 5^k, exact for all 32-bit words
    localparam logic [63:0] C_RCP1 = ((64'd1 << 32) + 64'd4) / 64'd5;
    localparam logic [63:0] C_RCP2 = ((64'd1 << 31) + 64'd24) / 64'd25;
    localparam logic [63:0] C_RCP3 = ((64'd1 << 30) + 64'd124) / 64'd125;
    localparam logic [63:0] C_RCP4 = ((64'd1 << 30) + 64'd624) / 64'd625;
    localparam logic [63:0] C_RCP5 = ((64'd1 << 29) + 64'd3124) / 64'd3125;

    typedef struct packed {
        logic [4:0][5:0] sym;   // low digits, least significant first
        logic [16:0]     top;   // quotient left after the last digit
    } t_symbols;

    typedef struct packed {
        logic               bad;
        logic               done;
        logic [C_LEN_W-1:0] length;
        logic [2:0]         count;
        logic [5:0][7:0]    chars;  // chars[0] is the first character
    } t_result;

    function automatic logic [7:0] f_sym_char(input logic [5:0] code);
        logic [7:0] c;
        unique case (code)
            6'd1:    c = "E";
            6'd2:    c = "A";
            6'd3:    c = "N";
            6'd4:    c = "I";
            6'd5:    c = "O";
            6'd6:    c = "R";
            6'd7:    c = "T";
            6'd8:    c = "S";
            6'd9:    c = "L";
            6'd10:   c = "C";
            6'd11:   c = "U";
            6'd12:   c = "D";
            6'd13:   c = "H";
            6'd14:   c = "M";
            6'd15:   c = "G";
            6'd16:   c = "B";
            6'd17:   c = "W";
            6'd18:   c = "K";
            6'd19:   c = "F";
            6'd20:   c = "V";
            6'd21:   c = "Y";
            6'd22:   c = "P";
            6'd23:   c = "X";
            6'd24:   c = "J";
            6'd25:   c = "Q";
            6'd26:   c = "Z";
            6'd27:   c = "-";
            6'd28:   c = "_";
            6'd29:   c = ".";
            6'd30:   c = "0";
            6'd31:   c = "1";
            6'd32:   c = "2";
            6'd33:   c = "3";
            6'd34:   c = "4";
            6'd35:   c = "5";
            6'd36:   c = "6";
            6'd37:   c = "7";
            6'd38:   c = "8";
            6'd39:   c = "9";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== src/r40ku_split.sv =====
`timescale 1ns / 1ps
// ============================================================================
// r40ku_split
// splits one packed word into base-40 digits with parallel reciprocal products
// ============================================================================
module r40ku_split (
    input  logic               [31:0] i_word,
    input  logic                      i_head,
    output r40ku_pkg::t_symbols       o_sym
);
    import r40ku_pkg::*;

    logic [58:0] w_p1;
    logic [52:0] w_p2;
    logic [46:0] w_p3;
    logic [40:0] w_p4;
    logic [34:0] w_p5;
    logic [26:0] w_q1;
    logic [21:0] w_q2;
    logic [16:0] w_q3;
    logic [10:0] w_q4;
    logic [5:0]  w_q5;

    // low digit from this quotient and the next: lo - 40 * next, mod 64
    function automatic logic [5:0] f_digit(input logic [5:0] lo, input logic [2:0] nx);
        logic [5:0] m;
        m = {nx[0], 5'b0} + {nx[2:0], 3'b0};
        return lo - m;
    endfunction

    assign w_p1 = 59'(i_word[31:3])  * 59'(C_RCP1[29:0]);
    assign w_p2 = 53'(i_word[31:6])  * 53'(C_RCP2[26:0]);
    assign w_p3 = 47'(i_word[31:9])  * 47'(C_RCP3[23:0]);
    assign w_p4 = 41'(i_word[31:12]) * 41'(C_RCP4[20:0]);
    assign w_p5 = 35'(i_word[31:15]) * 35'(C_RCP5[17:0]);

    assign w_q1 = w_p1[58:32];
    assign w_q2 = w_p2[52:31];
    assign w_q3 = w_p3[46:30];
    assign w_q4 = w_p4[40:30];
    assign w_q5 = w_p5[34:29];

    assign o_sym.sym[0] = f_digit(i_word[5:0], w_q1[2:0]);
    assign o_sym.sym[1] = f_digit(w_q1[5:0],   w_q2[2:0]);
    assign o_sym.sym[2] = f_digit(w_q2[5:0],   w_q3[2:0]);
    assign o_sym.sym[3] = f_digit(w_q3[5:0],   w_q4[2:0]);
    assign o_sym.sym[4] = f_digit(w_q4[5:0],   w_q5[2:0]);
    assign o_sym.top    = i_head ? w_q3 : 17'(w_q5);

endmodule

// ===== src/r40ku_decode.sv =====
`timescale 1ns / 1ps
// ============================================================================
// r40ku_decode
// maps digits to characters, finds the key end and updates the length
// ============================================================================
module r40ku_decode (
    input  r40ku_pkg::t_symbols                     i_sym,
    input  logic                                    i_head,
    input  logic                                    i_last,
    input  logic                                    i_stopped,
    input  logic [r40ku_pkg::C_LEN_W-1:0]           i_length,
    input  logic [r40ku_pkg::C_LEN_W-1:0]           i_len_cap,
    output r40ku_pkg::t_result                      o_res
);
    import r40ku_pkg::*;

    logic [2:0]         w_nd;
    logic               w_ended;
    logic               w_bad;
    logic [2:0]         w_cnt;
    logic [C_LEN_W-1:0] w_base;
    logic [C_LEN_W:0]   w_sum;

    always_comb begin
        w_nd    = i_head ? C_HEAD_DIGITS : C_REST_DIGITS;
        w_ended = 1'b0;
        w_bad   = 1'b0;
        w_cnt   = 3'd0;
        for (int k = 0; k < 5; k++) begin
            if ((3'(k) < w_nd) && !w_ended) begin
                if (i_sym.sym[k] == 6'd0) begin
                    w_ended = 1'b1;
                end else begin
                    w_cnt = w_cnt + 3'd1;
                end
            end
        end
        if (!w_ended) begin
            if (i_sym.top == 17'd0) begin
                w_ended = 1'b1;
            end else if (i_sym.top > C_TOP_MAX) begin
                w_bad   = 1'b1;
                w_ended = 1'b1;
            end else begin
                w_cnt = w_cnt + 3'd1;
            end
        end

        w_base = i_head ? '0 : i_length;
        w_sum  = {1'b0, w_base} + (C_LEN_W + 1)'(w_cnt);

        o_res = '0;
        if (!i_head && i_stopped) begin
            // key already ended: nothing decoded, length held
            o_res.length = i_length;
            o_res.done   = 1'b1;
        end else begin
            // characters before the end are contiguous, top symbol sits at w_nd
            for (int k = 0; k < 5; k++) begin
                if (3'(k) < w_cnt) begin
                    o_res.chars[k] = (3'(k) == w_nd) ? f_sym_char(i_sym.top[5:0])
                                                     : f_sym_char(i_sym.sym[k]);
                end
            end
            if (w_cnt == 3'd6) begin
                o_res.chars[5] = f_sym_char(i_sym.top[5:0]);
            end
            o_res.count  = w_cnt;
            o_res.length = (w_sum > {1'b0, i_len_cap}) ? i_len_cap : w_sum[C_LEN_W-1:0];
            o_res.done   = w_ended || i_last;
            o_res.bad    = w_bad;
        end
    end

endmodule

// ===== src/radix40_key_unpack_core.sv =====
`timescale 1ns / 1ps
// path: accepted items pass the input register, then the result register driving o_m_tvalid
// throughput: one item per cycle while i_m_tready does not stall the result register; the
//   decode between the two registers is a single pass of five parallel reciprocal products,
//   the alphabet table and the length add
// reset: synchronous active-low i_rst_n empties both registers, clears the key-ended
//   flag and the running length
// ============================================================================
// radix40_key_unpack_core
// unpacks base-40 key words into ascii characters, one word per item
// ============================================================================
`include "radix40_key_unpack_core_macros.svh"

module radix40_key_unpack_core #(
    parameter int MAX_REST_WORDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] packed_word
    input  logic        i_s_tlast,   // last_word
    input  logic [0:0]  i_s_tuser,   // [0] head_word
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [47:0] char_a..char_f, [50:48] char_count,
                                     // [57:51] key_length, [63:58] zero
    output logic        o_m_tlast,   // key_done
    output logic [0:0]  o_m_tuser    // [0] bad_symbol
);
    import r40ku_pkg::*;

    // length cap: head plus all rest words, limited by the 7-bit field
    localparam int KEY_LEN_FULL = 4 + 6 * MAX_REST_WORDS;
    localparam logic [C_LEN_W-1:0] KEY_LEN_CAP =
        (KEY_LEN_FULL > 127) ? 7'd127 : C_LEN_W'(KEY_LEN_FULL);

    // input register
    logic               r_in_valid, n_in_valid;
    logic [31:0]        r_in_word;
    logic               r_in_head;
    logic               r_in_last;

    // result register
    logic               r_out_valid, n_out_valid;
    t_result            r_out;

    // per-key state
    logic               r_stopped, n_stopped;
    logic [C_LEN_W-1:0] r_len, n_len;

    logic               w_adv;
    logic               w_load;
    t_symbols           w_sym;
    t_result            w_res;

    // an item moves from input to result register when the result slot frees
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_load     = i_s_tvalid && o_s_tready;

    r40ku_split u_split (
        .i_word (r_in_word),
        .i_head (r_in_head),
        .o_sym  (w_sym)
    );

    r40ku_decode u_decode (
        .i_sym     (w_sym),
        .i_head    (r_in_head),
        .i_last    (r_in_last),
        .i_stopped (r_stopped),
        .i_length  (r_len),
        .i_len_cap (KEY_LEN_CAP),
        .o_res     (w_res)
    );

    always_comb begin
        n_in_valid  = o_s_tready ? i_s_tvalid : r_in_valid;
        n_out_valid = w_adv ? 1'b1 : (i_m_tready ? 1'b0 : r_out_valid);
        // state follows the decoded item in order
        n_stopped   = w_adv ? w_res.done   : r_stopped;
        n_len       = w_adv ? w_res.length : r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_stopped   <= 1'b0;
            r_len       <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_stopped   <= n_stopped;
            r_len       <= n_len;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_word <= i_s_tdata;
            r_in_head <= i_s_tuser[0];
            r_in_last <= i_s_tlast;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {6'b0, r_out.length, r_out.count, r_out.chars};
    assign o_m_tlast    = r_out.done;
    assign o_m_tuser[0] = r_out.bad;

    // checks
    `R40KU_ASSERT(a_len_cap, r_len <= KEY_LEN_CAP, "running length above cap")
    `R40KU_ASSERT_IMPL(a_bad_ends_key, o_m_tvalid && o_m_tuser[0], o_m_tlast,
        "bad symbol without key end")
    `R40KU_ASSERT_IMPL(a_empty_no_chars, o_m_tvalid && (o_m_tdata[50:48] == 3'd0),
        o_m_tdata[47:0] == 48'd0, "characters given with zero count")
    `R40KU_ASSERT_NEXT(a_done_stops, w_adv && w_res.done, r_stopped,
        "key end not recorded")
    `R40KU_ASSERT_IMPL(a_count_range, o_m_tvalid, o_m_tdata[50:48] <= 3'd6,
        "character count above six")

endmodule
